>>> hw/rtl/sorted_merge_set_intersection_core_macros.svh
// assertion macros for the sorted-merge set intersection core
// no dependencies; included by the top level
`ifndef SORTED_MERGE_SET_INTERSECTION_CORE_MACROS_SVH
`define SORTED_MERGE_SET_INTERSECTION_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SMSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/smsi_pkg.sv
// shared types, constants and key helpers for the set intersection core
// no dependencies
package smsi_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_BITS  = 32;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [VALUE_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [RES_W-1:0]      res_cnt_t;

  typedef struct packed {
    logic               list_sel;
    logic               has_value;
    logic signed [31:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] common_value;
    logic               found;
    logic               last_res;
    logic               overflow;
  } out_res_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } list_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_MERGE
  } state_t;

  // biased key: sign bit flipped so unsigned order is signed order
  function automatic key_t to_key(logic [31:0] v);
    key_t k;
    k = key_t'(v);
    k[VALUE_BITS-1] = ~k[VALUE_BITS-1];
    return k;
  endfunction

  function automatic logic [31:0] from_key(key_t k);
    key_t v;
    v = k;
    v[VALUE_BITS-1] = ~v[VALUE_BITS-1];
    return 32'(v);
  endfunction

endpackage

>>> hw/rtl/smsi_cell.sv
// one sorter cell: holds a key, takes a new key or its left neighbor's on insert,
// takes its right neighbor's on pop; uses smsi_pkg
module smsi_cell (
  input  logic                clk,
  input  smsi_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  smsi_pkg::key_t      new_key,
  input  smsi_pkg::key_t      left_key,
  input  logic                left_gt,
  input  smsi_pkg::key_t      right_key,
  output smsi_pkg::key_t      key,
  output logic                gt
);

  // empty cells count as greater, so the insert point is the first greater cell
  assign gt = !occ || (key > new_key);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_gt) begin
        key <= left_key;
      end else if (gt) begin
        key <= new_key;
      end
    end else if (ctrl.pop) begin
      key <= right_key;
    end
  end

endmodule

>>> hw/rtl/smsi_list.sv
// one sorted list: a chain of smsi_cell with a fill count; head is the smallest key
// uses smsi_pkg and smsi_cell
module smsi_list (
  input  logic                 clk,
  input  logic                 rst,
  input  smsi_pkg::list_ctrl_t ctrl,
  input  smsi_pkg::key_t       new_key,
  output smsi_pkg::key_t       head,
  output smsi_pkg::cnt_t       count
);

  smsi_pkg::key_t       keys [smsi_pkg::DEPTH];
  logic                 gts  [smsi_pkg::DEPTH];
  smsi_pkg::cell_ctrl_t cctrl;

  assign cctrl.ins = ctrl.ins;
  assign cctrl.pop = ctrl.pop;
  assign head      = keys[0];

  for (genvar i = 0; i < smsi_pkg::DEPTH; i++) begin : g_cell
    smsi_pkg::key_t lk;
    smsi_pkg::key_t rk;
    logic           lg;
    logic           occ;

    assign occ = smsi_pkg::cnt_t'(i) < count;

    if (i == 0) begin : g_first
      assign lk = new_key;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lk = keys[i-1];
      assign lg = gts[i-1];
    end

    if (i == smsi_pkg::DEPTH - 1) begin : g_end
      assign rk = keys[i];
    end else begin : g_rest
      assign rk = keys[i+1];
    end

    smsi_cell u_cell (
      .clk       (clk),
      .ctrl      (cctrl),
      .occ       (occ),
      .new_key   (new_key),
      .left_key  (lk),
      .left_gt   (lg),
      .right_key (rk),
      .key       (keys[i]),
      .gt        (gts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      count <= '0;
    end else if (ctrl.ins) begin
      count <= count + smsi_pkg::cnt_t'(1);
    end else if (ctrl.pop) begin
      count <= count - smsi_pkg::cnt_t'(1);
    end
  end

endmodule

>>> hw/rtl/sorted_merge_set_intersection_core.sv
// top level of the sorted-merge set intersection core
// uses smsi_pkg, smsi_list (two chains of smsi_cell) and the assertion macro header
//
//   channel   handshake           payload           direction
//   request   start / busy        req (in_req_t)    in
//   result    strobe (one cycle)  res (out_res_t)   out
//
// loading: one request per cycle while busy is low; an element drops into sorted place
//   in its list's cell chain in the accepting cycle
// a request with last set holds busy high while the merge pops
//   one or both chain heads per cycle; results strobe at most one per cycle, the final one flagged
// synchronous reset clears counts, overflow and control; list cells are not cleared
// results cannot be stalled: the receiver must take every strobe
`include "sorted_merge_set_intersection_core_macros.svh"

module sorted_merge_set_intersection_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  smsi_pkg::in_req_t req,
  output logic              strobe,
  output smsi_pkg::out_res_t res
);

  smsi_pkg::state_t     state, state_next;
  smsi_pkg::list_ctrl_t ctrl_a, ctrl_b;
  smsi_pkg::key_t       new_key, head_a, head_b;
  smsi_pkg::cnt_t       cnt_a, cnt_b;

  // pending result: held back until we know whether it is the final one
  smsi_pkg::key_t     pend_key, pend_key_next;
  logic               pend_valid, pend_valid_next;
  smsi_pkg::res_cnt_t n, n_next;
  logic               ovf, ovf_next;
  logic               strobe_next;
  smsi_pkg::out_res_t res_next;

  logic accept;
  logic stop;

  assign busy    = (state == smsi_pkg::ST_MERGE);
  assign accept  = start && !busy;
  assign new_key = smsi_pkg::to_key(req.value);
  assign stop    = (cnt_a == '0) || (cnt_b == '0) ||
                   (n == smsi_pkg::res_cnt_t'(smsi_pkg::MAX_RESULTS));

  smsi_list u_list_a (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_a),
    .new_key (new_key),
    .head    (head_a),
    .count   (cnt_a)
  );

  smsi_list u_list_b (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl_b),
    .new_key (new_key),
    .head    (head_b),
    .count   (cnt_b)
  );

  always_comb begin
    state_next      = state;
    ctrl_a          = '0;
    ctrl_b          = '0;
    pend_key_next   = pend_key;
    pend_valid_next = pend_valid;
    n_next          = n;
    ovf_next        = ovf;
    strobe_next     = 1'b0;
    res_next        = res;

    case (state)
      smsi_pkg::ST_LOAD: begin
        if (accept) begin
          // insert the element, or note the overflow when its list is full
          if (req.has_value) begin
            if (!req.list_sel) begin
              if (cnt_a < smsi_pkg::cnt_t'(smsi_pkg::DEPTH)) begin
                ctrl_a.ins = 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end else begin
              if (cnt_b < smsi_pkg::cnt_t'(smsi_pkg::DEPTH)) begin
                ctrl_b.ins = 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end
          end
          if (req.last) begin
            state_next = smsi_pkg::ST_MERGE;
          end
        end
      end

      smsi_pkg::ST_MERGE: begin
        if (stop) begin
          // final result: pending common value, or the empty marker
          strobe_next           = 1'b1;
          res_next.found        = pend_valid;
          res_next.last_res     = 1'b1;
          res_next.overflow     = ovf;
          res_next.common_value = pend_valid ? smsi_pkg::from_key(pend_key) : '0;
          ctrl_a.clr            = 1'b1;
          ctrl_b.clr            = 1'b1;
          pend_valid_next       = 1'b0;
          n_next                = '0;
          ovf_next              = 1'b0;
          state_next            = smsi_pkg::ST_LOAD;
        end else if (head_a == head_b) begin
          ctrl_a.pop = 1'b1;
          ctrl_b.pop = 1'b1;
          // duplicates sit next to each other, so compare against the pending one
          if (!pend_valid || (pend_key != head_a)) begin
            if (pend_valid) begin
              strobe_next           = 1'b1;
              res_next.found        = 1'b1;
              res_next.last_res     = 1'b0;
              res_next.overflow     = ovf;
              res_next.common_value = smsi_pkg::from_key(pend_key);
            end
            pend_key_next   = head_a;
            pend_valid_next = 1'b1;
            n_next          = n + smsi_pkg::res_cnt_t'(1);
          end
        end else if (head_a > head_b) begin
          ctrl_b.pop = 1'b1;
        end else begin
          ctrl_a.pop = 1'b1;
        end
      end

      default: begin
        state_next = smsi_pkg::ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= smsi_pkg::ST_LOAD;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      n          <= '0;
      ovf        <= 1'b0;
    end else begin
      state      <= state_next;
      strobe     <= strobe_next;
      pend_valid <= pend_valid_next;
      n          <= n_next;
      ovf        <= ovf_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_key <= pend_key_next;
    res      <= res_next;
  end

  // the final result lands as the block drops back to loading
  `SMSI_ASSERT_NOW(a_final_not_busy, strobe && res.last_res, !busy,
    "final result strobed while still merging")

  // an empty marker always closes its run
  `SMSI_ASSERT_NOW(a_marker_final, strobe && !res.found, res.last_res,
    "empty marker not flagged as final")

  // consecutive results of one run rise strictly
  `SMSI_ASSERT_NEXT(a_ascending, strobe && res.found && !res.last_res,
    !strobe || ({~res.common_value[31], res.common_value[30:0]} >
                {~$past(res.common_value[31]), $past(res.common_value[30:0])}),
    "common values not strictly ascending")

endmodule
